### sv/arh_pkg.sv
// Shared types, codes and defaults for the auto-ranging histogram.
`timescale 1ns / 1ps

package arh_pkg;

	localparam int NUM_BINS_DEF    = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	// width_shift saturates here; no doubling past it
	localparam logic [4:0] WIDTH_MAX = 5'd31;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] ST_COUNTED = 2'd0;
	localparam logic [1:0] ST_NEG     = 2'd1;
	localparam logic [1:0] ST_READ    = 2'd2;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_NEG    = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] sample;
		logic        [3:0]  read_index;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  bin_index;
		logic [31:0] bin_count;
		logic [4:0]  width_shift;
		logic [30:0] bin_low_edge;
	} out_t;

	// classified command between front and back
	typedef struct packed {
		logic [1:0]  op;
		logic [30:0] value;
		logic [3:0]  read_index;
	} cmd_t;

endpackage

### sv/arh_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module arh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

### sv/arh_front.sv
// Front end: classifies incoming items and holds them in a two-entry queue.
`timescale 1ns / 1ps

module arh_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  arh_pkg::in_t  item,
	output logic          cmd_vld,
	output arh_pkg::cmd_t cmd,
	input  logic          cmd_pop
);

	arh_pkg::cmd_t cmd_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	arh_pkg::cmd_t cls;
	logic          do_push;
	logic          do_pop;

	always_comb begin
		cls.value      = item.sample[30:0];
		cls.read_index = item.read_index;
		if (item.kind == arh_pkg::KIND_READ) begin
			cls.op = arh_pkg::OP_READ;
		end else if (item.sample[31]) begin
			cls.op = arh_pkg::OP_NEG;
		end else begin
			cls.op = arh_pkg::OP_SAMPLE;
		end
	end

	assign full    = (cnt_q == 2'd2);
	assign cmd_vld = (cnt_q != 2'd0);
	assign cmd     = cmd_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = cmd_pop && cmd_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_q[wr_ptr_q] <= cls;
		end
	end

endmodule

### sv/arh_back.sv
// Back end: bin counters, merge sweep on doubling, bin update and result register.
`timescale 1ns / 1ps

module arh_back #(
	parameter int NUM_BINS    = arh_pkg::NUM_BINS_DEF,
	parameter int COUNT_WIDTH = arh_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_vld,
	input  arh_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_vld,
	output arh_pkg::out_t res,
	input  logic          res_pop
);

	localparam int IW   = $clog2(NUM_BINS);
	localparam int XW   = (IW > 4) ? IW : 4;
	localparam int HALF = NUM_BINS / 2;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_MERGE = 2'd1;
	localparam logic [1:0] S_MDONE = 2'd2;
	localparam logic [1:0] S_LOOK  = 2'd3;

	logic [1:0]          state_q;
	logic [4:0]          width_q;
	logic [NUM_BINS-1:0] valid_q;
	logic [IW-1:0]       mi_q;
	logic [XW-1:0]       idx_q;
	logic [1:0]          op_q;
	logic                va_s1;
	logic                vb_s1;
	logic                mw_vld_s1;
	logic [IW-1:0]       mw_addr_s1;
	arh_pkg::out_t       res_q;
	logic                res_vld_q;

	logic [30:0]            q;
	logic                   q_big;
	logic                   need_merge;
	logic                   go;
	logic                   neg_done;
	logic                   start_look;
	logic [XW-1:0]          new_idx;
	logic                   idx_in;
	logic [IW-1:0]          pair_a;
	logic [IW-1:0]          raddr_a;
	logic [IW-1:0]          raddr_b;
	logic [COUNT_WIDTH-1:0] rdata_a;
	logic [COUNT_WIDTH-1:0] rdata_b;
	logic [COUNT_WIDTH-1:0] cnt;
	logic [COUNT_WIDTH-1:0] inc;
	logic [COUNT_WIDTH-1:0] ma;
	logic [COUNT_WIDTH-1:0] mb;
	logic [COUNT_WIDTH:0]   sum_w;
	logic [COUNT_WIDTH-1:0] msum;
	logic                   we;
	logic [IW-1:0]          waddr;
	logic [COUNT_WIDTH-1:0] wdata;
	logic [NUM_BINS-1:0]    low_mask;
	logic [NUM_BINS-1:0]    valid_nxt;
	logic [63:0]            rep_ext;
	logic [31:0]            rep_cnt;
	arh_pkg::out_t          look_res;

	always_comb begin
		q          = cmd.value >> width_q;
		q_big      = (32'(q) >= NUM_BINS);
		need_merge = (cmd.op == arh_pkg::OP_SAMPLE) && (width_q != arh_pkg::WIDTH_MAX)
			&& q_big;
		go         = (state_q == S_IDLE) && cmd_vld && (!res_vld_q || res_pop);
		cmd_pop    = go && !need_merge;
		neg_done   = cmd_pop && (cmd.op == arh_pkg::OP_NEG);
		start_look = cmd_pop && (cmd.op != arh_pkg::OP_NEG);

		if (cmd.op == arh_pkg::OP_READ) begin
			new_idx = XW'(cmd.read_index);
		end else if (q_big) begin
			new_idx = XW'(NUM_BINS - 1);
		end else begin
			new_idx = XW'(q);
		end
		idx_in = (32'(new_idx) < NUM_BINS);

		pair_a  = IW'({mi_q, 1'b0});
		raddr_a = (state_q == S_MERGE) ? pair_a : new_idx[IW-1:0];
		raddr_b = pair_a | IW'(1);
	end

	arh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NUM_BINS)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	always_comb begin
		// entries never written since reset or last clear read as zero
		cnt   = va_s1 ? rdata_a : '0;
		inc   = (&cnt) ? cnt : cnt + COUNT_WIDTH'(1);
		ma    = va_s1 ? rdata_a : '0;
		mb    = vb_s1 ? rdata_b : '0;
		sum_w = {1'b0, ma} + {1'b0, mb};
		msum  = sum_w[COUNT_WIDTH] ? '1 : sum_w[COUNT_WIDTH-1:0];

		we    = mw_vld_s1 || ((state_q == S_LOOK) && (op_q == arh_pkg::OP_SAMPLE));
		waddr = mw_vld_s1 ? mw_addr_s1 : idx_q[IW-1:0];
		wdata = mw_vld_s1 ? msum : inc;

		for (int i = 0; i < NUM_BINS; i++) begin
			low_mask[i] = (i < HALF);
		end
		valid_nxt = valid_q;
		if (we) begin
			valid_nxt[waddr] = 1'b1;
		end
		if (state_q == S_MDONE) begin
			valid_nxt = valid_nxt & low_mask;
		end

		rep_ext = 64'((op_q == arh_pkg::OP_SAMPLE) ? inc : cnt);
		rep_cnt = (rep_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rep_ext[31:0];

		look_res.status       = (op_q == arh_pkg::OP_SAMPLE) ? arh_pkg::ST_COUNTED
			: arh_pkg::ST_READ;
		look_res.bin_index    = idx_q[3:0];
		look_res.bin_count    = rep_cnt;
		look_res.width_shift  = width_q;
		look_res.bin_low_edge = 31'(idx_q) << width_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			width_q   <= 5'd0;
			valid_q   <= '0;
			mi_q      <= '0;
			mw_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			valid_q   <= valid_nxt;
			mw_vld_s1 <= (state_q == S_MERGE);
			if (neg_done || (state_q == S_LOOK)) begin
				res_vld_q <= 1'b1;
			end else if (res_pop) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (go && need_merge) begin
						mi_q    <= '0;
						state_q <= S_MERGE;
					end else if (start_look) begin
						state_q <= S_LOOK;
					end
				end
				S_MERGE: begin
					if (32'(mi_q) == HALF - 1) begin
						state_q <= S_MDONE;
					end else begin
						mi_q <= mi_q + IW'(1);
					end
				end
				S_MDONE: begin
					// last pair sum lands now; re-check the waiting sample
					width_q <= width_q + 5'd1;
					state_q <= S_IDLE;
				end
				S_LOOK: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mw_addr_s1 <= mi_q;
		if (state_q == S_MERGE) begin
			va_s1 <= valid_q[raddr_a];
			vb_s1 <= valid_q[raddr_b];
		end else begin
			va_s1 <= idx_in && valid_q[raddr_a];
			vb_s1 <= 1'b0;
		end
		if (start_look) begin
			idx_q <= new_idx;
			op_q  <= cmd.op;
		end
		if (neg_done) begin
			res_q.status       <= arh_pkg::ST_NEG;
			res_q.bin_index    <= 4'd0;
			res_q.bin_count    <= 32'd0;
			res_q.width_shift  <= width_q;
			res_q.bin_low_edge <= 31'd0;
		end else if (state_q == S_LOOK) begin
			res_q <= look_res;
		end
	end

	assign res_vld = res_vld_q;
	assign res     = res_q;

endmodule

### sv/auto_ranging_histogram.sv
// Top level of the auto-ranging histogram.
// Input side is a queue: present item and raise push; the transaction happens on a
// clock edge with push high and full low. kind selects add-sample or read-bin.
// Result side is a single result register: while empty is low the waiting result sits on
// result; it is taken on an edge with pop high. Every item yields exactly one result.
// A negative sample is written straight into the result register when the engine
// takes it; an add or a read first reads its bin counter from the RAM, then writes
// the result register (and, for an add, the incremented counter) in a lookup state.
// An add that overflows the range first sums bin pairs, one pair per cycle, then
// doubles the width and retries; no new command is taken during lookup or merge.
// A two-entry command queue sits between the front end and the counter engine, so
// items keep being accepted while a result waits. If pop stays low the result holds,
// the engine takes no further command, and full rises after two more items.
// Reset (arst_n low) clears the width to one and marks every bin as zero; no
// clearing pass is needed, items are accepted from the first edge after reset.
`timescale 1ns / 1ps

module auto_ranging_histogram #(
	parameter int NUM_BINS    = arh_pkg::NUM_BINS_DEF,
	parameter int COUNT_WIDTH = arh_pkg::COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  arh_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output arh_pkg::out_t result
);

	logic          cmd_vld;
	logic          cmd_pop;
	arh_pkg::cmd_t cmd;
	logic          res_vld;

	arh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.cmd_vld(cmd_vld),
		.cmd    (cmd),
		.cmd_pop(cmd_pop)
	);

	arh_back #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_vld(cmd_vld),
		.cmd    (cmd),
		.cmd_pop(cmd_pop),
		.res_vld(res_vld),
		.res    (result),
		.res_pop(pop)
	);

	assign empty = !res_vld;

endmodule

### sv/arh_check.sv
// Port-level checks for the auto-ranging histogram, bound to the top level.
`timescale 1ns / 1ps

module arh_check (
	input logic          clk,
	input logic          arst_n,
	input logic          push,
	input logic          full,
	input arh_pkg::in_t  item,
	input logic          empty,
	input logic          pop,
	input arh_pkg::out_t result
);

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.status == arh_pkg::ST_NEG) |->
		(result.bin_index == 4'd0) && (result.bin_count == 32'd0)
		&& (result.bin_low_edge == 31'd0))
		else $error("ignored sample carries bin data");

	a_read_edge: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.status == arh_pkg::ST_READ) |->
		result.bin_low_edge == (31'(result.bin_index) << result.width_shift))
		else $error("read lower edge mismatch");

	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (result.status == arh_pkg::ST_COUNTED) |-> result.bin_count != 32'd0)
		else $error("counted bin reports zero");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status == arh_pkg::ST_COUNTED)
		|| (result.status == arh_pkg::ST_NEG) || (result.status == arh_pkg::ST_READ))
		else $error("undefined status code");

endmodule

bind auto_ranging_histogram arh_check u_arh_check (.*);
